/* src/pma_pkg.sv */
// Package for the paged MMU with aging page replacement.
// Holds request and status codes, the page-table entry layout and the result word.
// No dependencies.
package pma_pkg;

   localparam logic [2:0] REQ_READ = 3'd0;
   localparam logic [2:0] REQ_WRITE = 3'd1;
   localparam logic [2:0] REQ_EXEC = 3'd2;
   localparam logic [2:0] REQ_PROT = 3'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BOUNDARY = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_READ_DENIED = 3'd3;
   localparam logic [2:0] ST_WRITE_DENIED = 3'd4;
   localparam logic [2:0] ST_EXEC_DENIED = 3'd5;

   // Page-table entry fields other than the frame number.
   typedef struct packed {
      logic       valid;
      logic       dirty;
      logic [2:0] prot;
      logic [7:0] age;
   } entry_meta_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] phys_addr;
      logic [7:0] store_byte;
      logic       store_enable;
      logic       page_fault;
      logic [5:0] fill_page;
      logic [3:0] fill_frame;
      logic       evicted;
      logic       writeback;
      logic [5:0] evict_page;
   } result_type;

   // True when the protection bits allow an access of the given type.
   function automatic logic prot_allows(input logic [2:0] rtype, input logic [2:0] prot);
      logic ok;
      ok = 1'b0;
      unique case (rtype)
         REQ_READ: ok = prot[0];
         REQ_WRITE: ok = prot[1];
         default: ok = prot[2];
      endcase
      return ok;
   endfunction

   // Denied status for an access type.
   function automatic logic [2:0] denied_status(input logic [2:0] rtype);
      logic [2:0] st;
      st = ST_EXEC_DENIED;
      unique case (rtype)
         REQ_READ: st = ST_READ_DENIED;
         REQ_WRITE: st = ST_WRITE_DENIED;
         default: st = ST_EXEC_DENIED;
      endcase
      return st;
   endfunction

endpackage

/* src/pma_table.sv */
// Page-table memory: one write port and one read port, registered read data.
// No dependencies.
module pma_table #(
   parameter int DEPTH = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 17
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/paged_mmu_aging_replacement.sv */
// Top level of the paged MMU with aging page replacement.
// Depends on pma_pkg and pma_table.
//
// Usage. A request word (type, process id, virtual address, write byte,
// protection bits) is taken on the req_ channel when req_valid is high and
// req_stall is low. Exactly one response word follows on the rsp_ channel;
// it is held steady while rsp_stall is high. The block works on one request
// at a time and raises req_stall while it is busy, but a finished response
// may wait in the output register while the next request is already taken.
// Steps: an address outside the window or an unknown type is rejected
// before the lookup; a protection update or a denied hit finishes after the
// table read. A granted hit runs one aging pass over the page table. A page
// fault runs the aging pass (which also finds the victim) and installs the
// page, and finishes there when the access is then denied; a granted access
// runs a second aging pass. The block returns to idle before the next
// request is taken. Each pass sweeps the page-table memory one entry per
// cycle through its single read port. While the receiver stalls with the
// output register full, a finished response waits in the done state and no
// further request is taken. After reset the table is cleared in one pass
// over all entries, during which req_stall stays high. Frames are handed
// out in order from a fill count, so the lowest free frame is always the
// count itself.
module paged_mmu_aging_replacement
   import pma_pkg::*;
#(
   parameter int PAGE_BYTES = 16,
   parameter int NUM_PAGES = 64,
   parameter int NUM_FRAMES = 16,
   parameter int PROC_SPACE = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_type,
   input  logic [2:0] req_proc_id,
   input  logic [9:0] req_virt_addr,
   input  logic [7:0] req_write_byte,
   input  logic [2:0] req_prot_bits,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_phys_addr,
   output logic [7:0] rsp_store_byte,
   output logic       rsp_store_enable,
   output logic       rsp_page_fault,
   output logic [5:0] rsp_fill_page,
   output logic [3:0] rsp_fill_frame,
   output logic       rsp_evicted,
   output logic       rsp_writeback,
   output logic [5:0] rsp_evict_page
);

   localparam int PAGE_W = $clog2(NUM_PAGES);
   localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);
   localparam int OFF_W = $clog2(PAGE_BYTES);
   localparam int META_W = $bits(entry_meta_type);
   localparam int ENTRY_W = META_W + FRAME_W;
   // Exact division of a 10-bit value by a constant: multiply by a rounded-up
   // reciprocal and shift.
   localparam int DIV1_S = 10 + $clog2(PAGE_BYTES);
   localparam int DIV1_M = (2 ** DIV1_S + PAGE_BYTES - 1) / PAGE_BYTES;
   localparam int DIV2_S = 10 + $clog2(NUM_PAGES);
   localparam int DIV2_M = (2 ** DIV2_S + NUM_PAGES - 1) / NUM_PAGES;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DIV1 = 4'd2;
   localparam logic [3:0] S_DIV2 = 4'd3;
   localparam logic [3:0] S_DIV3 = 4'd4;
   localparam logic [3:0] S_LOOK = 4'd5;
   localparam logic [3:0] S_CHECK = 4'd6;
   localparam logic [3:0] S_SWEEP = 4'd7;
   localparam logic [3:0] S_ALLOC = 4'd8;
   localparam logic [3:0] S_INSTALL = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [2:0]         type_ff, type_in;
   logic [2:0]         pid_ff, pid_in;
   logic [9:0]         va_ff, va_in;
   logic [7:0]         wbyte_ff, wbyte_in;
   logic [2:0]         nprot_ff, nprot_in;
   logic [9:0]         q_ff, q_in;
   logic [9:0]         q2_ff, q2_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [2:0]         pprot_ff, pprot_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [PAGE_W-1:0]  idx_ff, idx_in;
   logic               issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [PAGE_W-1:0]  paddr_ff, paddr_in;
   logic               second_ff, second_in;
   logic [7:0]         tage_ff, tage_in;
   logic               have_ff, have_in;
   logic [PAGE_W-1:0]  best_ff, best_in;
   logic [7:0]         bage_ff, bage_in;
   logic [FRAME_W-1:0] bframe_ff, bframe_in;
   logic               bdirty_ff, bdirty_in;
   logic [2:0]         bprot_ff, bprot_in;
   logic [CNT_W-1:0]   fcount_ff, fcount_in;
   result_type         res_ff, res_in;
   result_type         out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic               wr_en, rd_en;
   logic [PAGE_W-1:0]  wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   entry_meta_type     rd_meta, wmeta;
   logic [FRAME_W-1:0] rd_frame;
   logic [7:0]         age_new;
   logic [31:0]        win_lo, win_hi, prod1, prod2, offw, pagew, physw, tmp_page, tmp_frame;
   logic [31:0]        tmp_best;

   pma_table #(
      .DEPTH  (NUM_PAGES),
      .ADDR_W (PAGE_W),
      .DATA_W (ENTRY_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_meta = entry_meta_type'(rd_data[ENTRY_W-1:FRAME_W]);
   assign rd_frame = rd_data[FRAME_W-1:0];
   // Halve the age; the touched page gets the top bit, which is adding 128.
   assign age_new = {paddr_ff == page_ff, rd_meta.age[7:1]};

   assign win_lo = 32'(pid_ff) * 32'(PROC_SPACE);
   assign win_hi = win_lo + 32'(PROC_SPACE);
   assign prod1 = 32'(va_ff) * 32'(DIV1_M);
   assign prod2 = 32'(q_ff) * 32'(DIV2_M);
   assign offw = 32'(va_ff) - 32'(q_ff) * 32'(PAGE_BYTES);
   assign pagew = 32'(q_ff) - 32'(q2_ff) * 32'(NUM_PAGES);
   assign physw = 32'(frame_in) * 32'(PAGE_BYTES) + 32'(off_ff);
   assign tmp_page = 32'(page_ff);
   assign tmp_frame = 32'(frame_in);
   assign tmp_best = 32'(best_ff);

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      type_in = type_ff;
      pid_in = pid_ff;
      va_in = va_ff;
      wbyte_in = wbyte_ff;
      nprot_in = nprot_ff;
      q_in = q_ff;
      q2_in = q2_ff;
      off_in = off_ff;
      page_in = page_ff;
      pprot_in = pprot_ff;
      frame_in = frame_ff;
      idx_in = idx_ff;
      issue_in = 1'b0;
      pend_in = 1'b0;
      paddr_in = idx_ff;
      second_in = second_ff;
      tage_in = tage_ff;
      have_in = have_ff;
      best_in = best_ff;
      bage_in = bage_ff;
      bframe_in = bframe_ff;
      bdirty_in = bdirty_ff;
      bprot_in = bprot_ff;
      fcount_in = fcount_ff;
      res_in = res_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      wr_en = 1'b0;
      wr_addr = page_ff;
      wr_data = '0;
      rd_en = 1'b0;
      rd_addr = page_ff;
      wmeta = rd_meta;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = idx_ff;
            if (idx_ff == PAGE_W'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               type_in = req_type;
               pid_in = req_proc_id;
               va_in = req_virt_addr;
               wbyte_in = req_write_byte;
               nprot_in = req_prot_bits;
               res_in = '0;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            q_in = 10'(prod1 >> DIV1_S);
            if (32'(va_ff) < win_lo || 32'(va_ff) >= win_hi) begin
               res_in.status = ST_BOUNDARY;
               state_in = S_DONE;
            end else if (type_ff > REQ_PROT) begin
               res_in.status = ST_INVALID;
               state_in = S_DONE;
            end else begin
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            off_in = offw[OFF_W-1:0];
            q2_in = 10'(prod2 >> DIV2_S);
            state_in = S_DIV3;
         end
         S_DIV3: begin
            page_in = pagew[PAGE_W-1:0];
            state_in = S_LOOK;
         end
         S_LOOK: begin
            rd_en = 1'b1;
            rd_addr = page_ff;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            pprot_in = rd_meta.prot;
            frame_in = rd_frame;
            idx_in = '0;
            issue_in = 1'b1;
            have_in = 1'b0;
            if (type_ff == REQ_PROT) begin
               wmeta.prot = nprot_ff;
               wr_en = 1'b1;
               wr_data = {wmeta, rd_frame};
               state_in = S_DONE;
            end else if (!rd_meta.valid) begin
               second_in = 1'b0;
               state_in = S_SWEEP;
            end else if (prot_allows(type_ff, rd_meta.prot)) begin
               res_in.phys_addr = physw[7:0];
               if (type_ff == REQ_WRITE) begin
                  res_in.store_byte = wbyte_ff;
                  res_in.store_enable = 1'b1;
               end
               second_in = 1'b1;
               state_in = S_SWEEP;
            end else begin
               res_in.status = denied_status(type_ff);
               state_in = S_DONE;
            end
         end
         S_SWEEP: begin
            // Read one entry a cycle; write the previous one back aged.
            rd_en = issue_ff;
            rd_addr = idx_ff;
            pend_in = issue_ff;
            paddr_in = idx_ff;
            if (issue_ff) begin
               if (idx_ff == PAGE_W'(NUM_PAGES - 1)) begin
                  issue_in = 1'b0;
               end else begin
                  issue_in = 1'b1;
                  idx_in = idx_ff + 1'b1;
               end
            end
            if (pend_ff) begin
               wmeta.age = age_new;
               if (second_ff && paddr_ff == page_ff && type_ff == REQ_WRITE) begin
                  wmeta.dirty = 1'b1;
               end
               wr_en = 1'b1;
               wr_addr = paddr_ff;
               wr_data = {wmeta, rd_frame};
               if (!second_ff) begin
                  if (paddr_ff == page_ff) begin
                     tage_in = age_new;
                  end
                  // Victim: lowest new age among resident pages, lowest index on ties.
                  if (rd_meta.valid && (!have_ff || age_new < bage_ff)) begin
                     have_in = 1'b1;
                     best_in = paddr_ff;
                     bage_in = age_new;
                     bframe_in = rd_frame;
                     bdirty_in = rd_meta.dirty;
                     bprot_in = rd_meta.prot;
                  end
               end
               if (paddr_ff == PAGE_W'(NUM_PAGES - 1)) begin
                  state_in = second_ff ? S_DONE : S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            if (fcount_ff < CNT_W'(NUM_FRAMES)) begin
               frame_in = fcount_ff[FRAME_W-1:0];
               fcount_in = fcount_ff + 1'b1;
            end else if (have_ff) begin
               frame_in = bframe_ff;
               res_in.evicted = 1'b1;
               res_in.writeback = bdirty_ff;
               res_in.evict_page = tmp_best[5:0];
               wmeta = '0;
               wmeta.prot = bprot_ff;
               wr_en = 1'b1;
               wr_addr = best_ff;
               wr_data = {wmeta, bframe_ff};
            end else begin
               frame_in = '0;
            end
            state_in = S_INSTALL;
         end
         S_INSTALL: begin
            wmeta.valid = 1'b1;
            wmeta.dirty = 1'b0;
            wmeta.prot = pprot_ff;
            wmeta.age = tage_ff;
            wr_en = 1'b1;
            wr_addr = page_ff;
            wr_data = {wmeta, frame_ff};
            res_in.page_fault = 1'b1;
            res_in.fill_page = tmp_page[5:0];
            res_in.fill_frame = tmp_frame[3:0];
            res_in.phys_addr = physw[7:0];
            idx_in = '0;
            issue_in = 1'b1;
            if (prot_allows(type_ff, pprot_ff)) begin
               if (type_ff == REQ_WRITE) begin
                  res_in.store_byte = wbyte_ff;
                  res_in.store_enable = 1'b1;
               end
               second_in = 1'b1;
               state_in = S_SWEEP;
            end else begin
               res_in.status = denied_status(type_ff);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_in = res_ff;
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff <= '0;
         issue_ff <= 1'b0;
         pend_ff <= 1'b0;
         fcount_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         issue_ff <= issue_in;
         pend_ff <= pend_in;
         fcount_ff <= fcount_in;
         out_valid_ff <= out_valid_in;
      end
      type_ff <= type_in;
      pid_ff <= pid_in;
      va_ff <= va_in;
      wbyte_ff <= wbyte_in;
      nprot_ff <= nprot_in;
      q_ff <= q_in;
      q2_ff <= q2_in;
      off_ff <= off_in;
      page_ff <= page_in;
      pprot_ff <= pprot_in;
      frame_ff <= frame_in;
      paddr_ff <= paddr_in;
      second_ff <= second_in;
      tage_ff <= tage_in;
      have_ff <= have_in;
      best_ff <= best_in;
      bage_ff <= bage_in;
      bframe_ff <= bframe_in;
      bdirty_ff <= bdirty_in;
      bprot_ff <= bprot_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_ff.status;
   assign rsp_phys_addr = out_ff.phys_addr;
   assign rsp_store_byte = out_ff.store_byte;
   assign rsp_store_enable = out_ff.store_enable;
   assign rsp_page_fault = out_ff.page_fault;
   assign rsp_fill_page = out_ff.fill_page;
   assign rsp_fill_frame = out_ff.fill_frame;
   assign rsp_evicted = out_ff.evicted;
   assign rsp_writeback = out_ff.writeback;
   assign rsp_evict_page = out_ff.evict_page;

   // The frame fill count never passes the number of frames.
   a_fcount_range: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= CNT_W'(NUM_FRAMES))
      else $error("frame fill count out of range");

   // An eviction only happens as part of a page fault.
   a_evict_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_page_fault)
      else $error("eviction without page fault");

   // A fault never accompanies a rejected request.
   a_fault_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_fault |-> rsp_status != ST_BOUNDARY && rsp_status != ST_INVALID)
      else $error("page fault on rejected request");

   // A store is only requested for a granted access.
   a_store_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_enable |-> rsp_status == ST_OK)
      else $error("store on denied access");

   // A sweep read always returns data to the following cycle.
   a_sweep_pipe: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWEEP && issue_ff |=> pend_ff)
      else $error("sweep read lost");

endmodule
